// File: design/rsde_pkg.sv
// Shared types and constants for the RISC subset decode/execute block.
// No dependencies; used by every other file through rsde_pkg:: scoped names.
package rsde_pkg;

  // Data memory geometry
  localparam int unsigned DATA_WORDS = 1024;
  localparam int unsigned DMEM_AW    = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  // Register file geometry
  localparam int unsigned RF_DEPTH = 32;
  localparam int unsigned RF_AW    = 5;
  localparam logic [RF_AW-1:0] ZERO_REG = 5'd31;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam logic [0:0]  CFG_IDX_DATA_BASE = 1'b0;

  // Input operations
  localparam logic OP_EXECUTE = 1'b0;
  localparam logic OP_PRELOAD = 1'b1;

  // Instruction categories, bits [31:29]
  localparam logic [2:0] CAT_BRANCH = 3'b001;
  localparam logic [2:0] CAT_ALUI   = 3'b010;
  localparam logic [2:0] CAT_ALUR   = 3'b011;
  localparam logic [2:0] CAT_MEM    = 3'b100;
  localparam logic [2:0] CAT_HALT   = 3'b101;

  // Compare-and-branch opcodes, bits [28:24]
  localparam logic [4:0] OPC_CBZ  = 5'd16;
  localparam logic [4:0] OPC_CBNZ = 5'd17;

  // Register-immediate opcodes, bits [28:22]
  localparam logic [6:0] OPC_ORRI = 7'd64;
  localparam logic [6:0] OPC_EORI = 7'd65;
  localparam logic [6:0] OPC_ADDI = 7'd66;
  localparam logic [6:0] OPC_SUBI = 7'd67;
  localparam logic [6:0] OPC_ANDI = 7'd68;

  // Register-register opcodes, bits [28:21]
  localparam logic [7:0] OPC_EOR = 8'd160;
  localparam logic [7:0] OPC_ADD = 8'd162;
  localparam logic [7:0] OPC_SUB = 8'd163;
  localparam logic [7:0] OPC_AND = 8'd164;
  localparam logic [7:0] OPC_ORR = 8'd165;
  localparam logic [7:0] OPC_LSR = 8'd166;
  localparam logic [7:0] OPC_LSL = 8'd167;

  // Load/store opcodes, bits [28:21]
  localparam logic [7:0] OPC_LDUR = 8'd170;
  localparam logic [7:0] OPC_STUR = 8'd171;

  // One executed transaction as it moves down the pipeline
  typedef struct packed {
    logic [31:0]      next_address;
    logic             branch_taken;
    logic             halted;
    logic             fault;
    logic             reg_write;
    logic [RF_AW-1:0] reg_index;
    logic [31:0]      reg_value;
    logic             mem_write;
    logic [31:0]      mem_address;
    logic [31:0]      mem_value;
    logic             is_load;
  } result_t;

  // Data memory access request
  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [DMEM_AW-1:0] idx;
    logic [31:0]        wdata;
  } dmem_req_t;

endpackage

// File: design/rsde_regfile.sv
// Register file: 32 x 32 synchronous RAM, two registered read ports, one write port.
// Valid bits make unwritten entries read as zero; X31 always reads zero. Uses rsde_pkg.
module rsde_regfile (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [rsde_pkg::RF_AW-1:0] rd_a_idx,
  input  logic [rsde_pkg::RF_AW-1:0] rd_b_idx,
  output logic [31:0]               rd_a_data,
  output logic [31:0]               rd_b_data,
  input  logic                      wr_en,
  input  logic [rsde_pkg::RF_AW-1:0] wr_idx,
  input  logic [31:0]               wr_data
);

  logic [31:0]                   rf_mem_r [rsde_pkg::RF_DEPTH];
  logic [rsde_pkg::RF_DEPTH-1:0] vld_r;
  logic [31:0]                   rd_a_raw_r;
  logic [31:0]                   rd_b_raw_r;
  logic                          rd_a_ok_r;
  logic                          rd_b_ok_r;
  logic                          wr_ok;

  assign wr_ok = wr_en && (wr_idx != rsde_pkg::ZERO_REG);

  // Write array and read both ports
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      rf_mem_r[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_a_raw_r <= rf_mem_r[rd_a_idx];
      rd_b_raw_r <= rf_mem_r[rd_b_idx];
    end
  end

  // Track written entries and sample their valid bits with the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_a_ok_r <= 1'b0;
      rd_b_ok_r <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_a_ok_r <= vld_r[rd_a_idx] && (rd_a_idx != rsde_pkg::ZERO_REG);
        rd_b_ok_r <= vld_r[rd_b_idx] && (rd_b_idx != rsde_pkg::ZERO_REG);
      end
    end
  end

  assign rd_a_data = rd_a_ok_r ? rd_a_raw_r : '0;
  assign rd_b_data = rd_b_ok_r ? rd_b_raw_r : '0;

endmodule

// File: design/rsde_dmem.sv
// Data memory: DATA_WORDS x 32 synchronous RAM, one access per cycle once not busy, registered read.
// Runs a clearing pass after reset and flags busy meanwhile. Uses rsde_pkg.
module rsde_dmem (
  input  logic                clk,
  input  logic                rst_n,
  input  rsde_pkg::dmem_req_t req,
  output logic [31:0]         rd_data,
  output logic                busy
);

  localparam logic [rsde_pkg::DMEM_AW-1:0] CLR_LAST =
    rsde_pkg::DMEM_AW'(rsde_pkg::DATA_WORDS - 1);

  logic [31:0]                  dmem_r [rsde_pkg::DATA_WORDS];
  logic [31:0]                  rd_data_r;
  logic [rsde_pkg::DMEM_AW-1:0] clr_idx_r;
  logic [rsde_pkg::DMEM_AW-1:0] clr_idx_nxt;
  logic                         busy_r;
  logic                         wr_any;
  logic [rsde_pkg::DMEM_AW-1:0] wr_idx;
  logic [31:0]                  wr_data;

  // Clearing pass has the write port while busy
  assign wr_any  = busy_r || req.wr_en;
  assign wr_idx  = busy_r ? clr_idx_r : req.idx;
  assign wr_data = busy_r ? '0 : req.wdata;

  always_ff @(posedge clk) begin
    if (wr_any) begin
      dmem_r[wr_idx] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= dmem_r[req.idx];
    end
  end

  // Advance clearing pointer, drop busy after the last word
  assign clr_idx_nxt = clr_idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else if (busy_r) begin
      clr_idx_r <= clr_idx_nxt;
      if (clr_idx_r == CLR_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

// File: design/rsde_exec.sv
// Decode and execute unit: combinational decode, ALU, branch and address mapping.
// Operands arrive already forwarded. Uses rsde_pkg for opcodes and result_t.
module rsde_exec (
  input  logic                          op,
  input  logic [31:0]                   word,
  input  logic [31:0]                   address,
  input  logic [31:0]                   a_val,
  input  logic [31:0]                   b_val,
  input  logic [31:0]                   data_base,
  output rsde_pkg::result_t             res,
  output logic [rsde_pkg::DMEM_AW-1:0]  dmem_idx
);

  logic [2:0]  cat;
  logic [31:0] pc_plus4;
  logic [31:0] br_off;
  logic [31:0] br_target;
  logic [31:0] uimm;
  logic [31:0] simm;
  logic [31:0] mem_off;
  logic [31:0] loc;
  logic [31:0] win_off;
  logic        win_ok;
  logic        br_cond;

  assign cat       = word[31:29];
  assign pc_plus4  = address + 32'd4;
  assign br_off    = {{13{word[18]}}, word[18:0]};
  assign br_target = address + {br_off[29:0], 2'b00};
  assign uimm      = {20'd0, word[11:0]};
  assign simm      = {{20{word[11]}}, word[11:0]};
  assign mem_off   = {{21{word[10]}}, word[10:0]};

  // Map data byte address into the window
  assign loc      = (op == rsde_pkg::OP_PRELOAD) ? address : (a_val + mem_off);
  assign win_off  = loc - data_base;
  assign win_ok   = (win_off[1:0] == 2'b00) &&
                    (win_off[31:2] < 30'(rsde_pkg::DATA_WORDS));
  assign dmem_idx = win_off[rsde_pkg::DMEM_AW+1:2];

  assign br_cond = (word[28:24] == rsde_pkg::OPC_CBZ) ? (a_val == '0) : (a_val != '0);

  always_comb begin
    res              = '0;
    res.next_address = pc_plus4;
    if (op == rsde_pkg::OP_PRELOAD) begin
      // Preload one data word
      res.next_address = '0;
      if (win_ok) begin
        res.mem_write   = 1'b1;
        res.mem_address = address;
        res.mem_value   = word;
      end else begin
        res.fault = 1'b1;
      end
    end else begin
      case (cat)
        rsde_pkg::CAT_BRANCH: begin
          if (word[28:24] inside {rsde_pkg::OPC_CBZ, rsde_pkg::OPC_CBNZ}) begin
            res.branch_taken = br_cond;
            if (br_cond) begin
              res.next_address = br_target;
            end
          end else begin
            res.fault = 1'b1;
          end
        end
        rsde_pkg::CAT_ALUI: begin
          res.reg_index = word[21:17];
          res.reg_write = 1'b1;
          case (word[28:22])
            rsde_pkg::OPC_ORRI: res.reg_value = a_val | uimm;
            rsde_pkg::OPC_EORI: res.reg_value = a_val ^ uimm;
            rsde_pkg::OPC_ADDI: res.reg_value = a_val + simm;
            rsde_pkg::OPC_SUBI: res.reg_value = a_val - simm;
            rsde_pkg::OPC_ANDI: res.reg_value = a_val & uimm;
            default: begin
              res.fault     = 1'b1;
              res.reg_write = 1'b0;
            end
          endcase
        end
        rsde_pkg::CAT_ALUR: begin
          res.reg_index = word[20:16];
          res.reg_write = 1'b1;
          case (word[28:21])
            rsde_pkg::OPC_EOR: res.reg_value = a_val ^ b_val;
            rsde_pkg::OPC_ADD: res.reg_value = a_val + b_val;
            rsde_pkg::OPC_SUB: res.reg_value = a_val - b_val;
            rsde_pkg::OPC_AND: res.reg_value = a_val & b_val;
            rsde_pkg::OPC_ORR: res.reg_value = a_val | b_val;
            rsde_pkg::OPC_LSR: res.reg_value = a_val >> b_val[4:0];
            rsde_pkg::OPC_LSL: res.reg_value = a_val << b_val[4:0];
            default: begin
              res.fault     = 1'b1;
              res.reg_write = 1'b0;
            end
          endcase
        end
        rsde_pkg::CAT_MEM: begin
          if (!(word[28:21] inside {rsde_pkg::OPC_LDUR, rsde_pkg::OPC_STUR})) begin
            res.fault = 1'b1;
          end else if (!win_ok) begin
            res.fault = 1'b1;
          end else if (word[28:21] == rsde_pkg::OPC_LDUR) begin
            // Value comes from the data memory one stage later
            res.reg_write = 1'b1;
            res.reg_index = word[20:16];
            res.is_load   = 1'b1;
          end else begin
            res.mem_write   = 1'b1;
            res.mem_address = loc;
            res.mem_value   = b_val;
          end
        end
        rsde_pkg::CAT_HALT: res.halted = 1'b1;
        default:            res.fault  = 1'b1;
      endcase
    end

    // Drop writes to X31 and zero unused write fields
    if (res.reg_write && (res.reg_index == rsde_pkg::ZERO_REG)) begin
      res.reg_write = 1'b0;
    end
    if (!res.reg_write) begin
      res.reg_index = '0;
      res.reg_value = '0;
      res.is_load   = 1'b0;
    end
  end

endmodule

// File: design/risc_subset_decode_execute.sv
// Top level of the RISC subset decode/execute block: handshakes, APB register,
// pipeline, forwarding and interlock. Uses rsde_pkg, rsde_regfile, rsde_dmem, rsde_exec.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    operation, word, address
//   out_     output     out_valid / out_ready  next_address ... mem_value
//   cfg      input      psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// Pipeline: accept (register file read) -> execute (data memory access) -> writeback
// into the output register, which drives out_valid.
// One transaction per cycle while nothing stalls; an instruction that uses the register of
// the load just before it is held in execute until the load has written back.
// After reset the data memory is cleared, one word a cycle (DATA_WORDS = 1024 words),
// with in_ready low; configuration writes are taken throughout.
// An output stall holds the pipeline back to in_ready without losing any transaction.
module risc_subset_decode_execute (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [31:0]                   in_word,
  input  logic [31:0]                   in_address,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_next_address,
  output logic                          out_branch_taken,
  output logic                          out_halted,
  output logic                          out_fault,
  output logic                          out_reg_write,
  output logic [4:0]                    out_reg_index,
  output logic signed [31:0]            out_reg_value,
  output logic                          out_mem_write,
  output logic [31:0]                   out_mem_address,
  output logic signed [31:0]            out_mem_value,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsde_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // Configuration
  logic [31:0] data_base_r;
  logic        cfg_sel_base;

  // Execute stage
  logic                       s1_vld_r;
  logic                       s1_op_r;
  logic [31:0]                s1_word_r;
  logic [31:0]                s1_addr_r;
  logic [rsde_pkg::RF_AW-1:0] s1_a_idx_r;
  logic [rsde_pkg::RF_AW-1:0] s1_b_idx_r;
  logic [rsde_pkg::RF_AW-1:0] rd_a_idx;
  logic [rsde_pkg::RF_AW-1:0] rd_b_idx;
  logic [31:0]                rf_a_data;
  logic [31:0]                rf_b_data;
  logic [31:0]                a_val;
  logic [31:0]                b_val;
  rsde_pkg::result_t          ex_res;
  logic [rsde_pkg::DMEM_AW-1:0] ex_dmem_idx;
  logic                       load_use;

  // Writeback stage
  logic                       s2_vld_r;
  rsde_pkg::result_t          s2_res_r;
  rsde_pkg::result_t          s2_final;
  logic [31:0]                s2_rval;

  // Output register
  logic                       out_vld_r;
  rsde_pkg::result_t          out_res_r;

  // Recent register writes, newest in wb0
  logic                       wb0_vld_r;
  logic [rsde_pkg::RF_AW-1:0] wb0_idx_r;
  logic [31:0]                wb0_val_r;
  logic                       wb1_vld_r;
  logic [rsde_pkg::RF_AW-1:0] wb1_idx_r;
  logic [31:0]                wb1_val_r;

  // Handshake and memory control
  logic                       in_acc;
  logic                       s1_adv;
  logic                       s2_adv;
  logic                       rf_wr_en;
  logic                       dmem_busy;
  logic [31:0]                dmem_rd_data;
  rsde_pkg::dmem_req_t        dmem_req;

  // APB register: one word, always ready
  assign cfg_sel_base = (paddr[rsde_pkg::PADDR_W-1:2] == rsde_pkg::CFG_IDX_DATA_BASE);
  assign pready       = 1'b1;
  assign prdata       = cfg_sel_base ? data_base_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_base_r <= '0;
    end else if (psel && penable && pwrite && cfg_sel_base) begin
      data_base_r <= pwdata;
    end
  end

  // Pipeline flow control
  assign s2_adv   = s2_vld_r && (!out_vld_r || out_ready);
  assign s1_adv   = s1_vld_r && !load_use && (!s2_vld_r || s2_adv);
  assign in_ready = !dmem_busy && (!s1_vld_r || s1_adv);
  assign in_acc   = in_valid && in_ready;

  // Pick register file read addresses from the incoming instruction
  always_comb begin
    case (in_word[31:29])
      rsde_pkg::CAT_BRANCH: rd_a_idx = in_word[23:19];
      rsde_pkg::CAT_ALUI:   rd_a_idx = in_word[16:12];
      default:              rd_a_idx = in_word[15:11];
    endcase
    rd_b_idx = (in_word[31:29] == rsde_pkg::CAT_ALUR) ? in_word[10:6] : in_word[20:16];
  end

  rsde_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_a_idx  (rd_a_idx),
    .rd_b_idx  (rd_b_idx),
    .rd_a_data (rf_a_data),
    .rd_b_data (rf_b_data),
    .wr_en     (rf_wr_en),
    .wr_idx    (s2_res_r.reg_index),
    .wr_data   (s2_rval)
  );

  // Capture accepted transaction into the execute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_operation;
      s1_word_r  <= in_word;
      s1_addr_r  <= in_address;
      s1_a_idx_r <= rd_a_idx;
      s1_b_idx_r <= rd_b_idx;
    end
  end

  // Forward pending and recent writes over stale register file data
  function automatic logic [31:0] fwd_operand(
    input logic [rsde_pkg::RF_AW-1:0] idx,
    input logic [31:0]                rf_data,
    input logic                       s2_hit_ok,
    input rsde_pkg::result_t          s2_res,
    input logic                       wb0_vld,
    input logic [rsde_pkg::RF_AW-1:0] wb0_idx,
    input logic [31:0]                wb0_val,
    input logic                       wb1_vld,
    input logic [rsde_pkg::RF_AW-1:0] wb1_idx,
    input logic [31:0]                wb1_val
  );
    logic [31:0] val;
    if (idx == rsde_pkg::ZERO_REG) begin
      val = '0;
    end else if (s2_hit_ok && s2_res.reg_write && (s2_res.reg_index == idx)) begin
      val = s2_res.reg_value;
    end else if (wb0_vld && (wb0_idx == idx)) begin
      val = wb0_val;
    end else if (wb1_vld && (wb1_idx == idx)) begin
      val = wb1_val;
    end else begin
      val = rf_data;
    end
    return val;
  endfunction

  assign a_val = fwd_operand(s1_a_idx_r, rf_a_data, s2_vld_r, s2_res_r,
                             wb0_vld_r, wb0_idx_r, wb0_val_r,
                             wb1_vld_r, wb1_idx_r, wb1_val_r);
  assign b_val = fwd_operand(s1_b_idx_r, rf_b_data, s2_vld_r, s2_res_r,
                             wb0_vld_r, wb0_idx_r, wb0_val_r,
                             wb1_vld_r, wb1_idx_r, wb1_val_r);

  // Hold an instruction that needs a load value not yet read out
  assign load_use = s2_vld_r && s2_res_r.is_load &&
                    ((s2_res_r.reg_index == s1_a_idx_r) ||
                     (s2_res_r.reg_index == s1_b_idx_r));

  rsde_exec u_exec (
    .op        (s1_op_r),
    .word      (s1_word_r),
    .address   (s1_addr_r),
    .a_val     (a_val),
    .b_val     (b_val),
    .data_base (data_base_r),
    .res       (ex_res),
    .dmem_idx  (ex_dmem_idx)
  );

  // Data memory access issues as the transaction leaves execute
  always_comb begin
    dmem_req.wr_en = s1_adv && ex_res.mem_write;
    dmem_req.rd_en = s1_adv && ex_res.is_load;
    dmem_req.idx   = ex_dmem_idx;
    dmem_req.wdata = ex_res.mem_value;
  end

  rsde_dmem u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dmem_req),
    .rd_data (dmem_rd_data),
    .busy    (dmem_busy)
  );

  // Writeback stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s2_vld_r <= 1'b1;
    end else if (s2_adv) begin
      s2_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_res_r <= ex_res;
    end
  end

  assign s2_rval  = s2_res_r.is_load ? dmem_rd_data : s2_res_r.reg_value;
  assign rf_wr_en = s2_adv && s2_res_r.reg_write;

  always_comb begin
    s2_final           = s2_res_r;
    s2_final.reg_value = s2_rval;
  end

  // Remember the last two register writes for forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb0_vld_r <= 1'b0;
      wb1_vld_r <= 1'b0;
    end else if (rf_wr_en) begin
      wb0_vld_r <= 1'b1;
      wb1_vld_r <= wb0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_wr_en) begin
      wb0_idx_r <= s2_res_r.reg_index;
      wb0_val_r <= s2_rval;
      wb1_idx_r <= wb0_idx_r;
      wb1_val_r <= wb0_val_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s2_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_res_r <= s2_final;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_next_address = out_res_r.next_address;
  assign out_branch_taken = out_res_r.branch_taken;
  assign out_halted       = out_res_r.halted;
  assign out_fault        = out_res_r.fault;
  assign out_reg_write    = out_res_r.reg_write;
  assign out_reg_index    = out_res_r.reg_index;
  assign out_reg_value    = $signed(out_res_r.reg_value);
  assign out_mem_write    = out_res_r.mem_write;
  assign out_mem_address  = out_res_r.mem_address;
  assign out_mem_value    = $signed(out_res_r.mem_value);

  // Faulting transactions never report a write
  a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.fault |-> !out_res_r.reg_write && !out_res_r.mem_write)
    else $error("faulting transaction reports a write");

  // X31 is never written
  a_no_x31_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_wr_en |-> s2_res_r.reg_index != rsde_pkg::ZERO_REG)
    else $error("register file write aimed at X31");

  // A load-use interlock releases once the load has written back
  a_load_use_release: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && load_use && s2_adv |=> !load_use && s1_vld_r)
    else $error("load-use interlock did not release");

  // No data memory traffic while the clearing pass runs
  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dmem_busy |-> !dmem_req.wr_en && !dmem_req.rd_en && !s1_vld_r)
    else $error("data memory access during clearing pass");

endmodule

// File: dv/risc_subset_decode_execute_tb.sv
// Self-checking testbench for risc_subset_decode_execute: directed and random instruction
// streams, an in-line execute predictor, and result checking. Depends on rsde_pkg and the RTL.
module risc_subset_decode_execute_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam logic [4:0]  SCRATCH_REG = 5'd19;

  // One retired transaction as seen on the result channel
  typedef struct packed {
    logic [31:0] next_address;
    logic        branch_taken;
    logic        halted;
    logic        fault;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [31:0] mem_value;
  } retire_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                         in_valid;
  logic                         in_ready;
  logic                         in_operation;
  logic [31:0]                  in_word;
  logic [31:0]                  in_address;
  logic                         out_valid;
  logic                         out_ready;
  logic [31:0]                  out_next_address;
  logic                         out_branch_taken;
  logic                         out_halted;
  logic                         out_fault;
  logic                         out_reg_write;
  logic [4:0]                   out_reg_index;
  logic signed [31:0]           out_reg_value;
  logic                         out_mem_write;
  logic [31:0]                  out_mem_address;
  logic signed [31:0]           out_mem_value;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rsde_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  // Architectural state mirrored by the predictor
  bit [31:0]   arch_regs [rsde_pkg::RF_DEPTH];
  bit [31:0]   data_mem [rsde_pkg::DATA_WORDS];
  logic [31:0] data_base = '0;

  retire_t     expected_retires [$];
  int          errors = 0;
  int          items_sent = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          long_stall = 0;
  int unsigned cycle_count = 0;

  risc_subset_decode_execute i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_word          (in_word),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_next_address (out_next_address),
    .out_branch_taken (out_branch_taken),
    .out_halted       (out_halted),
    .out_fault        (out_fault),
    .out_reg_write    (out_reg_write),
    .out_reg_index    (out_reg_index),
    .out_reg_value    (out_reg_value),
    .out_mem_write    (out_mem_write),
    .out_mem_address  (out_mem_address),
    .out_mem_value    (out_mem_value),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] reg_read(logic [4:0] idx);
    return (idx == rsde_pkg::ZERO_REG) ? 32'd0 : arch_regs[idx];
  endfunction

  // Map a byte address into the data window; fail on misalignment or overrun
  function automatic bit window_slot(input logic [31:0] byte_addr,
                                     output logic [rsde_pkg::DMEM_AW-1:0] slot);
    logic [31:0] offset;
    offset = byte_addr - data_base;
    slot = offset[rsde_pkg::DMEM_AW+1:2];
    return (offset[1:0] == 2'b00) && ((offset >> 2) < rsde_pkg::DATA_WORDS);
  endfunction

  // Execute one transaction against the mirrored state and return its result
  function automatic retire_t execute_model(logic op, logic [31:0] w, logic [31:0] pc);
    retire_t                      r;
    logic [31:0]                  a;
    logic [31:0]                  b;
    logic [31:0]                  loc;
    logic [rsde_pkg::DMEM_AW-1:0] slot;
    r = '0;
    r.next_address = pc + 32'd4;
    if (op == rsde_pkg::OP_PRELOAD) begin
      r.next_address = '0;
      if (window_slot(pc, slot)) begin
        data_mem[slot] = w;
        r.mem_write = 1'b1;
        r.mem_address = pc;
        r.mem_value = w;
      end else begin
        r.fault = 1'b1;
      end
    end else begin
      case (w[31:29])
        rsde_pkg::CAT_BRANCH: begin
          a = reg_read(w[23:19]);
          if (w[28:24] == rsde_pkg::OPC_CBZ || w[28:24] == rsde_pkg::OPC_CBNZ) begin
            r.branch_taken = (w[28:24] == rsde_pkg::OPC_CBZ) ? (a == 0) : (a != 0);
            if (r.branch_taken) r.next_address = pc + {{11{w[18]}}, w[18:0], 2'b00};
          end else begin
            r.fault = 1'b1;
          end
        end
        rsde_pkg::CAT_ALUI: begin
          a = reg_read(w[16:12]);
          r.reg_index = w[21:17];
          case (w[28:22])
            rsde_pkg::OPC_ORRI: r.reg_value = a | {20'd0, w[11:0]};
            rsde_pkg::OPC_EORI: r.reg_value = a ^ {20'd0, w[11:0]};
            rsde_pkg::OPC_ADDI: r.reg_value = a + {{20{w[11]}}, w[11:0]};
            rsde_pkg::OPC_SUBI: r.reg_value = a - {{20{w[11]}}, w[11:0]};
            rsde_pkg::OPC_ANDI: r.reg_value = a & {20'd0, w[11:0]};
            default:            r.fault = 1'b1;
          endcase
          r.reg_write = !r.fault;
        end
        rsde_pkg::CAT_ALUR: begin
          a = reg_read(w[15:11]);
          b = reg_read(w[10:6]);
          r.reg_index = w[20:16];
          case (w[28:21])
            rsde_pkg::OPC_EOR: r.reg_value = a ^ b;
            rsde_pkg::OPC_ADD: r.reg_value = a + b;
            rsde_pkg::OPC_SUB: r.reg_value = a - b;
            rsde_pkg::OPC_AND: r.reg_value = a & b;
            rsde_pkg::OPC_ORR: r.reg_value = a | b;
            rsde_pkg::OPC_LSR: r.reg_value = a >> b[4:0];
            rsde_pkg::OPC_LSL: r.reg_value = a << b[4:0];
            default:           r.fault = 1'b1;
          endcase
          r.reg_write = !r.fault;
        end
        rsde_pkg::CAT_MEM: begin
          loc = reg_read(w[15:11]) + {{21{w[10]}}, w[10:0]};
          if (w[28:21] != rsde_pkg::OPC_LDUR && w[28:21] != rsde_pkg::OPC_STUR) begin
            r.fault = 1'b1;
          end else if (!window_slot(loc, slot)) begin
            r.fault = 1'b1;
          end else if (w[28:21] == rsde_pkg::OPC_LDUR) begin
            r.reg_write = 1'b1;
            r.reg_index = w[20:16];
            r.reg_value = data_mem[slot];
          end else begin
            r.mem_value = reg_read(w[20:16]);
            data_mem[slot] = r.mem_value;
            r.mem_write = 1'b1;
            r.mem_address = loc;
          end
        end
        rsde_pkg::CAT_HALT: r.halted = 1'b1;
        default:            r.fault = 1'b1;
      endcase
    end

    // Drop writes to the zero register; zero the unused write fields
    if (r.reg_write && r.reg_index == rsde_pkg::ZERO_REG) r.reg_write = 1'b0;
    if (!r.reg_write) begin
      r.reg_index = '0;
      r.reg_value = '0;
    end else begin
      arch_regs[r.reg_index] = r.reg_value;
    end
    if (!r.mem_write) begin
      r.mem_address = '0;
      r.mem_value = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors and checking
  // ---------------------------------------------------------------------------

  function automatic string describe(retire_t r);
    return {$sformatf("next=%h br=%b halt=%b fault=%b rw=%b ridx=%0d ",
                      r.next_address, r.branch_taken, r.halted, r.fault, r.reg_write,
                      r.reg_index),
            $sformatf("rval=%h mw=%b maddr=%h mval=%h",
                      r.reg_value, r.mem_write, r.mem_address, r.mem_value)};
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // Append one prediction behind the older ones
  task automatic enqueue_expected(retire_t r);
    expected_retires.insert(expected_retires.size(), r);
  endtask

  // Predict each accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      enqueue_expected(execute_model(in_operation, in_word, in_address));
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_retire
    retire_t got;
    retire_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_next_address, out_branch_taken, out_halted, out_fault, out_reg_write,
             out_reg_index, out_reg_value, out_mem_write, out_mem_address, out_mem_value};
      if (expected_retires.size() == 0) begin
        flag_error($sformatf("unexpected result at %0t: %s", $time, describe(got)));
      end else begin
        want = expected_retires.pop_front();
        if (got !== want)
          flag_error($sformatf("mismatch at %0t\n  expected %s\n  actual   %s",
                               $time, describe(want), describe(got)));
      end
    end
  end

  // Drive result backpressure; a long hold-off overrides the random stalls
  always @(posedge clk) begin
    if (long_stall > 0) begin
      out_ready <= 1'b0;
      long_stall <= long_stall - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("risc_subset_decode_execute_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one transaction and hold it until accepted; called at a rising edge
  task automatic send_item(logic op, logic [31:0] w, logic [31:0] a);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_word <= w;
    in_address <= a;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_exec(logic [31:0] w);
    send_item(rsde_pkg::OP_EXECUTE, w, $urandom());
  endtask

  // Stop offering and wait until every predicted result has been checked
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_retires.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the data window base through the register port
  task automatic write_data_base(logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= rsde_pkg::PADDR_W'({rsde_pkg::CFG_IDX_DATA_BASE, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    data_base = value;
  endtask

  function automatic logic [31:0] enc_branch(logic [4:0] opc, logic [4:0] rt,
                                             logic [18:0] offset);
    return {rsde_pkg::CAT_BRANCH, opc, rt, offset};
  endfunction

  function automatic logic [31:0] enc_alui(logic [6:0] opc, logic [4:0] rd, logic [4:0] rn,
                                           logic [11:0] imm);
    return {rsde_pkg::CAT_ALUI, opc, rd, rn, imm};
  endfunction

  function automatic logic [31:0] enc_alur(logic [7:0] opc, logic [4:0] rd, logic [4:0] rn,
                                           logic [4:0] rm);
    return {rsde_pkg::CAT_ALUR, opc, rd, rn, rm, 6'($urandom())};
  endfunction

  function automatic logic [31:0] enc_mem(logic [7:0] opc, logic [4:0] rt, logic [4:0] rn,
                                          logic [10:0] offset);
    return {rsde_pkg::CAT_MEM, opc, rt, rn, offset};
  endfunction

  // Favor a few low registers so results feed the next instructions
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(3) == 0) ? 5'($urandom()) : 5'($urandom_range(7));
  endfunction

  function automatic logic [31:0] random_instruction();
    int k;
    k = $urandom_range(6);
    case ($urandom_range(9))
      0: return enc_branch($urandom_range(1) ? rsde_pkg::OPC_CBZ : rsde_pkg::OPC_CBNZ,
                           pick_reg(), 19'($urandom()));
      1, 2: return enc_alui(7'(rsde_pkg::OPC_ORRI + $urandom_range(4)), pick_reg(),
                            pick_reg(), 12'($urandom()));
      3, 4, 5: return enc_alur((k == 0) ? rsde_pkg::OPC_EOR : 8'(rsde_pkg::OPC_ADD + k - 1),
                               pick_reg(), pick_reg(), pick_reg());
      6: return {rsde_pkg::CAT_HALT, 29'($urandom())};
      7: return enc_mem($urandom_range(1) ? rsde_pkg::OPC_LDUR : rsde_pkg::OPC_STUR,
                        pick_reg(), pick_reg(), 11'($urandom()));
      default: return {3'($urandom_range(1, 4)), 29'($urandom())};
    endcase
  endfunction

  // Load or store near a window pointer, now and then off the grid or off the pointer
  function automatic logic [31:0] random_access(logic [4:0] ptr);
    logic [10:0] offset;
    logic [4:0]  base_reg;
    offset = 11'($urandom_range(32) * 4 - 64);
    if ($urandom_range(9) == 0) offset = 11'($urandom());
    base_reg = ($urandom_range(9) == 0) ? pick_reg() : ptr;
    return enc_mem($urandom_range(1) ? rsde_pkg::OPC_LDUR : rsde_pkg::OPC_STUR,
                   pick_reg(), base_reg, offset);
  endfunction

  // Build a 32-bit constant in rd from immediates and shifts
  task automatic load_constant(logic [4:0] rd, logic [31:0] value);
    send_exec(enc_alui(rsde_pkg::OPC_ORRI, SCRATCH_REG, rsde_pkg::ZERO_REG, 12'd12));
    send_exec(enc_alui(rsde_pkg::OPC_ORRI, rd, rsde_pkg::ZERO_REG, value[31:20]));
    send_exec(enc_alur(rsde_pkg::OPC_LSL, rd, rd, SCRATCH_REG));
    send_exec(enc_alui(rsde_pkg::OPC_ORRI, rd, rd, value[19:8]));
    send_exec(enc_alui(rsde_pkg::OPC_ORRI, SCRATCH_REG, rsde_pkg::ZERO_REG, 12'd8));
    send_exec(enc_alur(rsde_pkg::OPC_LSL, rd, rd, SCRATCH_REG));
    send_exec(enc_alui(rsde_pkg::OPC_ORRI, rd, rd, {4'd0, value[7:0]}));
  endtask

  // One random sequence: pointer setup plus accesses, single instructions,
  // preloads, or raw noise
  task automatic random_sequence();
    int          pick;
    logic [4:0]  ptr;
    logic [31:0] target;
    pick = $urandom_range(99);
    ptr = 5'(20 + $urandom_range(3));
    if (pick < 12) begin
      load_constant(ptr, data_base + 4 * $urandom_range(rsde_pkg::DATA_WORDS - 1));
      repeat ($urandom_range(3, 8)) send_exec(random_access(ptr));
    end else if (pick < 70) begin
      send_exec(random_instruction());
    end else if (pick < 82) begin
      send_exec(random_access(ptr));
    end else if (pick < 92) begin
      target = ($urandom_range(4) == 0) ? $urandom()
               : data_base + 4 * $urandom_range(rsde_pkg::DATA_WORDS - 1);
      send_item(rsde_pkg::OP_PRELOAD, $urandom(), target);
    end else begin
      send_item(1'($urandom()), $urandom(), $urandom());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Preload the last window word, then one word past the end and an unaligned address
  task automatic test_preload();
    send_item(rsde_pkg::OP_PRELOAD, 32'h8000_0000, 32'h0000_0FFC);
    send_item(rsde_pkg::OP_PRELOAD, 32'h1234_5678, 32'h0000_1000);
    send_item(rsde_pkg::OP_PRELOAD, 32'hDEAD_BEEF, 32'h0000_0002);
  endtask

  // Every ALU operation but register ADD, with immediate extremes and a write to the zero register
  task automatic test_alu();
    send_exec(enc_alui(rsde_pkg::OPC_ADDI, 5'd1, rsde_pkg::ZERO_REG, 12'hFFF));
    send_exec(enc_alui(rsde_pkg::OPC_SUBI, 5'd2, rsde_pkg::ZERO_REG, 12'h800));
    send_exec(enc_alui(rsde_pkg::OPC_ORRI, 5'd3, rsde_pkg::ZERO_REG, 12'hFFF));
    send_exec(enc_alui(rsde_pkg::OPC_EORI, 5'd4, 5'd1, 12'h800));
    send_exec(enc_alui(rsde_pkg::OPC_ANDI, rsde_pkg::ZERO_REG, 5'd1, 12'hFFF));
    send_exec(enc_alur(rsde_pkg::OPC_SUB, 5'd6, rsde_pkg::ZERO_REG, 5'd1));
    send_exec(enc_alur(rsde_pkg::OPC_EOR, 5'd7, 5'd1, 5'd3));
    send_exec(enc_alur(rsde_pkg::OPC_AND, 5'd8, 5'd4, 5'd3));
    send_exec(enc_alur(rsde_pkg::OPC_ORR, 5'd9, 5'd2, 5'd3));
    send_exec(enc_alur(rsde_pkg::OPC_LSR, 5'd10, 5'd1, 5'd3));
    send_exec(enc_alur(rsde_pkg::OPC_LSL, 5'd11, 5'd1, 5'd6));
  endtask

  // Offset extremes, misaligned and out-of-window accesses, and a load used at once
  task automatic test_memory();
    send_exec(enc_mem(rsde_pkg::OPC_LDUR, 5'd12, 5'd3, 11'h7FD));
    send_exec(enc_mem(rsde_pkg::OPC_STUR, 5'd1, rsde_pkg::ZERO_REG, 11'd4));
    send_exec(enc_mem(rsde_pkg::OPC_LDUR, 5'd13, 5'd2, 11'h400));
    send_exec(enc_mem(rsde_pkg::OPC_LDUR, 5'd14, 5'd6, 11'h3FF));
    send_exec(enc_mem(rsde_pkg::OPC_STUR, 5'd1, rsde_pkg::ZERO_REG, 11'd2));
    send_exec(enc_mem(rsde_pkg::OPC_LDUR, 5'd15, 5'd1, 11'd0));
    send_exec(enc_mem(rsde_pkg::OPC_LDUR, 5'd16, rsde_pkg::ZERO_REG, 11'd4));
    send_exec(enc_alur(rsde_pkg::OPC_ADD, 5'd17, 5'd16, 5'd16));
  endtask

  // Taken and not-taken branches with wrapping targets, then halt
  task automatic test_branch_halt();
    send_item(rsde_pkg::OP_EXECUTE,
              enc_branch(rsde_pkg::OPC_CBZ, rsde_pkg::ZERO_REG, 19'h3FFFF), 32'hFFFF_FFF0);
    send_item(rsde_pkg::OP_EXECUTE,
              enc_branch(rsde_pkg::OPC_CBNZ, rsde_pkg::ZERO_REG, 19'd0), 32'hFFFF_FFFC);
    send_item(rsde_pkg::OP_EXECUTE,
              enc_branch(rsde_pkg::OPC_CBNZ, 5'd1, 19'h40000), 32'h0000_0000);
    send_exec(enc_branch(rsde_pkg::OPC_CBZ, 5'd1, 19'd1));
    send_exec({rsde_pkg::CAT_HALT, 29'h1FFF_FFFF});
  endtask

  // Unknown categories and an unknown opcode
  task automatic test_illegal();
    send_exec(32'h0000_0000);
    send_exec(32'hFFFF_FFFF);
    send_exec(enc_alur(8'd161, 5'd5, 5'd1, 5'd2));
  endtask

  // Random traffic with one window base and one idle mix
  task automatic test_random_phase(int send_pct, int recv_pct, logic [31:0] base, int count);
    int first;
    drain_results();
    recv_idle <= recv_pct;
    send_idle = send_pct;
    write_data_base(base);
    first = items_sent;
    while (items_sent - first < count) random_sequence();
  endtask

  // Hold the result channel off long enough for the input side to stall
  task automatic test_backpressure();
    drain_results();
    long_stall <= 300;
    send_idle = 0;
    repeat (40) random_sequence();
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_word = '0;
    in_address = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle = 14;
    recv_idle = 49;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_data_base(32'h0000_0000);
    test_preload();
    test_alu();
    test_memory();
    test_branch_halt();
    test_illegal();
    test_random_phase(14, 49, 32'hFFFF_FFFF, 430);
    test_backpressure();
    test_random_phase(49, 14, 32'hFFFF_FE00, 430);
    test_random_phase(0, 0, $urandom(), 430);

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("risc_subset_decode_execute_tb: done, clean");
    end else begin
      $display("risc_subset_decode_execute_tb: done, errors");
    end
    $finish;
  end

endmodule
